[design/cmcc_pkg.sv]
`default_nettype none
package cmcc_pkg;

    localparam int LEGS           = 6;
    localparam int INPUTS_PER_LEG = 4;
    localparam int DEVICES        = 3;
    localparam int CHANNELS       = 8;

    localparam int SLOT_COUNT = LEGS * INPUTS_PER_LEG;
    localparam int PAIR_COUNT = DEVICES * CHANNELS;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int PAIR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic [2:0] leg_index;
        logic [2:0] slot_input;
        logic [2:0] device_number;
        logic [3:0] channel_number;
    } in_item_t;

    typedef struct packed {
        logic accepted;
        logic map_complete;
    } out_item_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [CH_W-1:0]  ch;
    } map_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic flag_set;
        logic flag_clr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_ok;
        logic scan_fail;
        logic scan_done;
    } sts_t;

endpackage
`default_nettype wire

[design/cmcc_datapath.sv]
`default_nettype none
module cmcc_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmcc_pkg::in_item_t s_data,
    input  wire cmcc_pkg::cmd_t     cmd,
    output cmcc_pkg::sts_t          sts,
    output cmcc_pkg::out_item_t     m_data
);

    cmcc_pkg::map_entry_t map_mem [cmcc_pkg::SLOT_COUNT];

    logic [cmcc_pkg::SLOT_COUNT-1:0] marks_reg, marks_next;
    logic [cmcc_pkg::PAIR_COUNT-1:0] scratch_reg, scratch_next;
    logic [cmcc_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [cmcc_pkg::SLOT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic                            rd_mark_reg, rd_mark_next;
    cmcc_pkg::map_entry_t            rd_entry_reg;
    logic                            flag_reg, flag_next;
    logic                            acc_reg, acc_next;
    cmcc_pkg::out_item_t             out_reg, out_next;

    logic                            in_ok;
    logic [cmcc_pkg::SLOT_W-1:0]     wr_addr;
    logic                            issue;
    logic [cmcc_pkg::PAIR_W-1:0]     pair;
    logic                            chk_ok;

    assign in_ok = ({1'b0, s_data.leg_index} < 4'(cmcc_pkg::LEGS)) &&
                   ({1'b0, s_data.slot_input} < 4'(cmcc_pkg::INPUTS_PER_LEG)) &&
                   ({1'b0, s_data.device_number} < 4'(cmcc_pkg::DEVICES)) &&
                   ({1'b0, s_data.channel_number} < 5'(cmcc_pkg::CHANNELS));

    assign wr_addr = cmcc_pkg::SLOT_W'(
                         cmcc_pkg::SLOT_W'(s_data.leg_index) *
                         cmcc_pkg::SLOT_W'(cmcc_pkg::INPUTS_PER_LEG)) +
                     cmcc_pkg::SLOT_W'(s_data.slot_input);

    assign issue = cmd.scan_run &&
                   (rd_idx_reg != cmcc_pkg::CNT_W'(cmcc_pkg::SLOT_COUNT));

    assign pair = cmcc_pkg::PAIR_W'(
                      cmcc_pkg::PAIR_W'(rd_entry_reg.dev) *
                      cmcc_pkg::PAIR_W'(cmcc_pkg::CHANNELS)) +
                  cmcc_pkg::PAIR_W'(rd_entry_reg.ch);

    // unrecorded slot fails before its stored pair is looked at
    assign chk_ok = rd_mark_reg && !scratch_reg[pair];

    assign sts.in_ok     = in_ok;
    assign sts.scan_fail = rd_vld_reg && !chk_ok;
    assign sts.scan_done = rd_vld_reg && chk_ok &&
                           (chk_idx_reg == cmcc_pkg::SLOT_W'(cmcc_pkg::SLOT_COUNT - 1));

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && in_ok) begin
            map_mem[wr_addr] <= '{dev: s_data.device_number[cmcc_pkg::DEV_W-1:0],
                                  ch:  s_data.channel_number[cmcc_pkg::CH_W-1:0]};
        end
        if (issue) begin
            rd_entry_reg <= map_mem[rd_idx_reg[cmcc_pkg::SLOT_W-1:0]];
        end
    end

    always_comb begin
        marks_next   = marks_reg;
        scratch_next = scratch_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        rd_vld_next  = rd_vld_reg;
        rd_mark_next = rd_mark_reg;
        flag_next    = flag_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;

        if (cmd.load) begin
            acc_next     = in_ok;
            scratch_next = '0;
            rd_idx_next  = '0;
            rd_vld_next  = 1'b0;
            if (in_ok) begin
                marks_next[wr_addr] = 1'b1;
            end
        end

        if (cmd.scan_run) begin
            rd_vld_next = issue;
            if (issue) begin
                rd_mark_next = marks_reg[rd_idx_reg[cmcc_pkg::SLOT_W-1:0]];
                chk_idx_next = rd_idx_reg[cmcc_pkg::SLOT_W-1:0];
                rd_idx_next  = rd_idx_reg + 1'b1;
            end
            if (rd_vld_reg && chk_ok) begin
                scratch_next[pair] = 1'b1;
            end
        end

        if (cmd.flag_set) begin
            flag_next = 1'b1;
        end else if (cmd.flag_clr) begin
            flag_next = 1'b0;
        end

        if (cmd.out_load) begin
            out_next.accepted     = acc_reg;
            out_next.map_complete = flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg  <= '0;
            flag_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            marks_reg  <= marks_next;
            flag_reg   <= flag_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scratch_reg <= scratch_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        rd_mark_reg <= rd_mark_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

    a_complete_needs_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flag_set |-> (&marks_reg))
        else $error("map flagged complete with an unrecorded slot");

    a_fail_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.scan_fail && sts.scan_done))
        else $error("scan reports both failure and completion");

endmodule
`default_nettype wire

[design/cmcc_ctrl.sv]
`default_nettype none
module cmcc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire cmcc_pkg::sts_t sts,
    output cmcc_pkg::cmd_t      cmd
);

    cmcc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == cmcc_pkg::ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cmcc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_ok ? cmcc_pkg::ST_SCAN : cmcc_pkg::ST_RESP;
                end
            end
            cmcc_pkg::ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_fail) begin
                    cmd.flag_clr = 1'b1;
                    state_next   = cmcc_pkg::ST_RESP;
                end else if (sts.scan_done) begin
                    cmd.flag_set = 1'b1;
                    state_next   = cmcc_pkg::ST_RESP;
                end
            end
            cmcc_pkg::ST_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cmcc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cmcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmcc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_reject_skips_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !sts.in_ok) |=> (state_reg == cmcc_pkg::ST_RESP))
        else $error("rejected transaction entered the scan");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_scan_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_run |-> !s_ready)
        else $error("input taken during scan");

endmodule
`default_nettype wire

[design/channel_map_completeness_checker.sv]
// Channel map completeness checker.
// Input channel s_valid/s_ready/s_data carries one calibration record: leg,
// input within the leg, converter device and channel. Result channel
// m_valid/m_ready/m_data returns one transaction per record: accepted and
// map_complete.
// A record with any field out of range is rejected: no entry, mark or flag
// changes and map_complete repeats the stored flag; m_valid rises once the
// result loads. An accepted record writes its slot entry and mark, then the
// map is scanned one slot per cycle through a registered read of the entry
// memory; the scan stops at the first unrecorded slot or repeated
// device/channel pair, and m_valid rises once the scan ends and the result
// loads. One record is in work at a time: the next is accepted the cycle
// after the result loads, and may be accepted while the previous result
// still waits. Reset clears all marks and the complete flag; entry contents
// are never used before their slot is recorded. A stalled receiver holds
// the result register, and a finished scan waits until it is free.
`default_nettype none
module channel_map_completeness_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cmcc_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cmcc_pkg::out_item_t      m_data
);

    cmcc_pkg::cmd_t cmd;
    cmcc_pkg::sts_t sts;

    cmcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cmcc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
